@@ hw/rtl/fpba_pkg.sv @@
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and codes for the fit policy block allocator: item and result
// payloads, operation, policy and register codes, and the cell control group.
// ----------------------------------------------------------------------------
`default_nettype none

package fpba_pkg;

    // Operation codes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_ALLOC   = 2'd1;
    localparam logic [1:0] OP_RESTORE = 2'd2;

    // Fit policies (unused code behaves as first fit)
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_FIT_POLICY  = 2'd0;
    localparam logic [1:0] REG_FIXED_PART  = 2'd1;
    localparam logic [1:0] REG_BLOCK_COUNT = 2'd2;

    localparam logic [4:0] BLOCK_COUNT_RST = 5'd16;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  block_index;
        logic [15:0] size;
        logic        last_request;
    } t_item;

    typedef struct packed {
        logic        granted;
        logic [3:0]  chosen_block;
        logic [15:0] leftover;
        logic [15:0] block_original;
        logic [15:0] refused_count;
    } t_result;

    // Broadcast control to every cell of the chain
    typedef struct packed {
        logic       load;
        logic       restore;
        logic       commit;
        logic       fixed;
        logic [1:0] policy;
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ hw/rtl/fit_policy_block_allocator.sv @@
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Block table with first, best and worst fit allocation over a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Items come in on i_item and are taken at a rising edge with start high
//   and busy low. Each item gives one result on o_result, marked by
//   o_result_valid for exactly one cycle; the receiver cannot hold it off.
//   Load, restore and unknown ops: result in the cycle after the accept,
//   and the next item may follow straight away (1 cycle per transaction).
//   Allocate: the request walks the chain of NUM_BLOCKS cells, one cell per
//   cycle, carrying the best candidate; the choice from the last cell is then
//   committed to its block. busy stays high for the whole walk and falls as
//   the result appears, so the next allocate is taken only after that. The
//   chain length sets how long the walk lasts.
//   Configuration goes through the APB port (0x0 policy, 0x4 fixed
//   partitions, 0x8 block count); the user must write it only while idle, as the block itself does not enforce it.
//   Reset clears the registers to first fit, dynamic, sixteen blocks, and
//   zeroes the refused count; block sizes are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module fit_policy_block_allocator #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_WIDTH = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // command channel
    input  wire                  start,
    output logic                 busy,
    input  fpba_pkg::t_item      i_item,
    // result channel
    output logic                 o_result_valid,
    output fpba_pkg::t_result    o_result,
    // APB configuration
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [3:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_SEARCH = 1'b1;

    // ---------------- configuration ----------------
    logic [1:0] r_fit_policy;
    logic       r_fixed;
    logic [4:0] r_block_count;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            fpba_pkg::REG_FIT_POLICY:  prdata = {30'd0, r_fit_policy};
            fpba_pkg::REG_FIXED_PART:  prdata = {31'd0, r_fixed};
            fpba_pkg::REG_BLOCK_COUNT: prdata = {27'd0, r_block_count};
            default:                   prdata = '0;
        endcase
    end

    // ---------------- control state ----------------
    logic              r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [15:0]       r_refused, n_refused;
    logic              r_res_valid, n_res_valid;
    fpba_pkg::t_result r_result, n_result;
    logic [SIZE_WIDTH-1:0] r_req_size;
    logic              r_last;

    logic accept;
    logic search_done;
    logic load_hit;
    logic [15:0] refused_upd;

    // chain taps: entry 0 feeds cell 0, entry NUM_BLOCKS is the final pick
    logic                  c_valid [NUM_BLOCKS+1];
    logic [IDX_W-1:0]      c_idx   [NUM_BLOCKS+1];
    logic [SIZE_WIDTH-1:0] c_rem   [NUM_BLOCKS+1];
    logic [SIZE_WIDTH-1:0] c_orig  [NUM_BLOCKS+1];

    logic [SIZE_WIDTH-1:0] fin_left;
    logic [IDX_W-1:0]      sel_idx;
    logic [SIZE_WIDTH-1:0] wr_data;
    fpba_pkg::t_cell_ctrl  ctrl;

    assign busy        = (r_state == S_SEARCH);
    assign accept      = start && !busy;
    assign search_done = (r_state == S_SEARCH) && (r_cnt == CNT_W'(NUM_BLOCKS));
    // loads beyond the table are dropped
    assign load_hit    = accept && (i_item.op == fpba_pkg::OP_LOAD)
                         && (int'(i_item.block_index) < NUM_BLOCKS);
    assign fin_left    = c_rem[NUM_BLOCKS] - r_req_size;
    // saturating refusal count
    assign refused_upd = (r_refused != 16'hFFFF) ? (r_refused + 16'd1) : r_refused;

    // commit and load never share a cycle: commit only while busy
    assign sel_idx = search_done ? c_idx[NUM_BLOCKS] : IDX_W'(i_item.block_index);
    assign wr_data = search_done ? fin_left : SIZE_WIDTH'(i_item.size);

    always_comb begin
        ctrl         = '0;
        ctrl.load    = load_hit;
        ctrl.restore = accept && (i_item.op == fpba_pkg::OP_RESTORE);
        ctrl.commit  = search_done && c_valid[NUM_BLOCKS];
        ctrl.fixed   = r_fixed;
        ctrl.policy  = r_fit_policy;
    end

    // ---------------- cell chain ----------------
    assign c_valid[0] = 1'b0;
    assign c_idx[0]   = '0;
    assign c_rem[0]   = '0;
    assign c_orig[0]  = '0;

    for (genvar j = 0; j < NUM_BLOCKS; j++) begin : g_cell
        logic cell_en;
        assign cell_en = (j < int'(r_block_count));

        fpba_cell #(
            .IDX_W  (IDX_W),
            .SIZE_W (SIZE_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_en        (cell_en),
            .i_index     (IDX_W'(j)),
            .i_sel_idx   (sel_idx),
            .i_wr_data   (wr_data),
            .i_req_size  (r_req_size),
            .i_in_valid  (c_valid[j]),
            .i_in_idx    (c_idx[j]),
            .i_in_rem    (c_rem[j]),
            .i_in_orig   (c_orig[j]),
            .o_out_valid (c_valid[j+1]),
            .o_out_idx   (c_idx[j+1]),
            .o_out_rem   (c_rem[j+1]),
            .o_out_orig  (c_orig[j+1])
        );
    end

    // ---------------- sequencing ----------------
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_refused   = r_refused;
        n_res_valid = 1'b0;
        n_result    = r_result;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_item.op == fpba_pkg::OP_ALLOC) begin
                        n_state = S_SEARCH;
                        n_cnt   = '0;
                    end else begin
                        // load, restore, unknown: report the current count
                        n_res_valid            = 1'b1;
                        n_result               = '0;
                        n_result.refused_count = r_refused;
                    end
                end
            end
            S_SEARCH: begin
                if (search_done) begin
                    n_state     = S_IDLE;
                    n_res_valid = 1'b1;
                    n_result    = '0;
                    if (c_valid[NUM_BLOCKS]) begin
                        n_result.granted        = 1'b1;
                        n_result.chosen_block   = 4'(c_idx[NUM_BLOCKS]);
                        n_result.leftover       = 16'(fin_left);
                        n_result.block_original = 16'(c_orig[NUM_BLOCKS]);
                        n_result.refused_count  = r_refused;
                        n_refused               = r_last ? 16'd0 : r_refused;
                    end else begin
                        n_result.refused_count  = refused_upd;
                        n_refused               = r_last ? 16'd0 : refused_upd;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= '0;
            r_refused     <= '0;
            r_res_valid   <= 1'b0;
            r_fit_policy  <= fpba_pkg::POL_FIRST;
            r_fixed       <= 1'b0;
            r_block_count <= fpba_pkg::BLOCK_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_refused   <= n_refused;
            r_res_valid <= n_res_valid;
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    fpba_pkg::REG_FIT_POLICY:  r_fit_policy  <= pwdata[1:0];
                    fpba_pkg::REG_FIXED_PART:  r_fixed       <= pwdata[0];
                    fpba_pkg::REG_BLOCK_COUNT: r_block_count <= pwdata[4:0];
                    default: ;
                endcase
            end
        end
    end

    // request payload held for the walk down the chain
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (accept) begin
            r_req_size <= SIZE_WIDTH'(i_item.size);
            r_last     <= i_item.last_request;
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_result;

    // ---------------- assertions ----------------
    a_accept_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_result_valid || busy))
        else $error("accepted transaction neither answered nor in search");

    a_busy_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("search ended without a result");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_cnt <= CNT_W'(NUM_BLOCKS)))
        else $error("search counter overran the chain");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.granted) |->
        (o_result.chosen_block == 4'd0 && o_result.leftover == 16'd0
         && o_result.block_original == 16'd0))
        else $error("refused result carries block fields");

    a_no_result_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> !o_result_valid)
        else $error("result strobe during search");

endmodule

`default_nettype wire

@@ hw/rtl/fpba_cell.sv @@
// ----------------------------------------------------------------------------
// fpba_cell
// One block of the table: holds its original and remaining size, and passes
// the best candidate so far on to the next cell, registered every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_cell #(
    parameter int IDX_W  = 4,
    parameter int SIZE_W = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  fpba_pkg::t_cell_ctrl    i_ctrl,
    input  wire                     i_en,
    input  wire  [IDX_W-1:0]        i_index,
    input  wire  [IDX_W-1:0]        i_sel_idx,
    input  wire  [SIZE_W-1:0]       i_wr_data,
    input  wire  [SIZE_W-1:0]       i_req_size,
    input  wire                     i_in_valid,
    input  wire  [IDX_W-1:0]        i_in_idx,
    input  wire  [SIZE_W-1:0]       i_in_rem,
    input  wire  [SIZE_W-1:0]       i_in_orig,
    output logic                    o_out_valid,
    output logic [IDX_W-1:0]        o_out_idx,
    output logic [SIZE_W-1:0]       o_out_rem,
    output logic [SIZE_W-1:0]       o_out_orig
);

    logic [SIZE_W-1:0] r_orig;
    logic [SIZE_W-1:0] r_rem;
    logic              r_cand_valid;
    logic [IDX_W-1:0]  r_cand_idx;
    logic [SIZE_W-1:0] r_cand_rem;
    logic [SIZE_W-1:0] r_cand_orig;

    logic sel_hit;
    logic eligible;
    logic better;
    logic take;

    assign sel_hit  = (i_sel_idx == i_index);
    assign eligible = i_en && (r_rem >= i_req_size) && !(i_ctrl.fixed && (r_rem < r_orig));

    always_comb begin
        better = 1'b0;
        if (i_ctrl.policy == fpba_pkg::POL_BEST) begin
            better = (r_rem < i_in_rem);
        end else if (i_ctrl.policy == fpba_pkg::POL_WORST) begin
            better = (r_rem > i_in_rem);
        end
    end

    // lower index already held wins ties
    assign take = eligible && (!i_in_valid || better);

    // block storage
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && sel_hit) begin
            r_orig <= i_wr_data;
            r_rem  <= i_wr_data;
        end else if (i_ctrl.commit && sel_hit) begin
            r_rem  <= i_wr_data;
        end else if (i_ctrl.restore) begin
            r_rem  <= r_orig;
        end
    end

    // candidate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_valid <= 1'b0;
        end else begin
            r_cand_valid <= take || i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cand_idx  <= i_index;
            r_cand_rem  <= r_rem;
            r_cand_orig <= r_orig;
        end else begin
            r_cand_idx  <= i_in_idx;
            r_cand_rem  <= i_in_rem;
            r_cand_orig <= i_in_orig;
        end
    end

    assign o_out_valid = r_cand_valid;
    assign o_out_idx   = r_cand_idx;
    assign o_out_rem   = r_cand_rem;
    assign o_out_orig  = r_cand_orig;

endmodule

`default_nettype wire

@@ verif/fpba_scoreboard_pkg.sv @@
// ----------------------------------------------------------------------------
// fpba_scoreboard_pkg
// Block table tracker for the allocator bench: keeps its own copy of block
// sizes, refused count and registers, predicts each transaction's result and
// checks what comes out of the block against it in order.
// ----------------------------------------------------------------------------
package fpba_scoreboard_pkg;

    import fpba_pkg::*;

    localparam int NUM_BLOCKS   = 16;
    localparam int REPORT_LIMIT = 10;
    localparam logic [15:0] REFUSED_MAX = 16'hFFFF;

    class alloc_scoreboard;
        logic [1:0]  policy;
        logic        fixed_mode;
        logic [4:0]  count_reg;
        logic [15:0] remaining [NUM_BLOCKS];
        logic [15:0] original  [NUM_BLOCKS];
        logic [15:0] refused;
        t_result     pending_results [$];
        int          mismatches;

        function new();
            policy     = POL_FIRST;
            fixed_mode = 1'b0;
            count_reg  = BLOCK_COUNT_RST;
            refused    = '0;
            mismatches = 0;
            foreach (remaining[i]) begin
                remaining[i] = '0;
                original[i]  = '0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_FIT_POLICY:  policy     = value[1:0];
                REG_FIXED_PART:  fixed_mode = value[0];
                REG_BLOCK_COUNT: count_reg  = value[4:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_FIT_POLICY:  return 32'(policy);
                REG_FIXED_PART:  return 32'(fixed_mode);
                REG_BLOCK_COUNT: return 32'(count_reg);
                default:         return '0;
            endcase
        endfunction

        function void flag(string msg);
            if (mismatches < REPORT_LIMIT)
                $display("%s", msg);
            mismatches++;
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
                flag($sformatf("%s mismatch: expected %0d, got %0d", field, want, got));
        endfunction

        // Updates the block table and works out the transaction's result
        function t_result apply_command(t_item it);
            t_result r;
            int      span;
            int      pick;
            r    = '0;
            pick = -1;
            case (it.op)
                OP_LOAD: begin
                    original[it.block_index]  = it.size;
                    remaining[it.block_index] = it.size;
                end
                OP_RESTORE: begin
                    foreach (remaining[i])
                        remaining[i] = original[i];
                end
                OP_ALLOC: begin
                    span = (count_reg > NUM_BLOCKS) ? NUM_BLOCKS : int'(count_reg);
                    for (int j = 0; j < span; j++) begin
                        if (fixed_mode && remaining[j] < original[j])
                            continue;
                        if (remaining[j] < it.size)
                            continue;
                        // strict compares keep ties on the lowest index
                        if (pick < 0)
                            pick = j;
                        else if (policy == POL_BEST && remaining[j] < remaining[pick])
                            pick = j;
                        else if (policy == POL_WORST && remaining[j] > remaining[pick])
                            pick = j;
                    end
                    if (pick >= 0) begin
                        remaining[pick]  = remaining[pick] - it.size;
                        r.granted        = 1'b1;
                        r.chosen_block   = pick[3:0];
                        r.leftover       = remaining[pick];
                        r.block_original = original[pick];
                    end else if (refused != REFUSED_MAX) begin
                        refused++;
                    end
                end
                default: ;
            endcase
            r.refused_count = refused;
            if (it.op == OP_ALLOC && it.last_request)
                refused = '0;
            return r;
        endfunction

        function void note_command(t_item it);
            pending_results = {pending_results, apply_command(it)};
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                flag($sformatf("result with nothing pending: %h", got));
                return;
            end
            want = pending_results.pop_front();
            compare("granted",        32'(want.granted),        32'(got.granted));
            compare("chosen_block",   32'(want.chosen_block),   32'(got.chosen_block));
            compare("leftover",       32'(want.leftover),       32'(got.leftover));
            compare("block_original", 32'(want.block_original), 32'(got.block_original));
            compare("refused_count",  32'(want.refused_count),  32'(got.refused_count));
        endfunction
    endclass

endpackage

@@ verif/fit_policy_block_allocator_tb.sv @@
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_tb
// Self-checking bench for the fit policy block allocator. Loads the block
// table, runs a short directed sequence, then random loads, restores and
// allocate requests across several register settings and idle patterns,
// checking every result against a tracked copy of the block table.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fpba_pkg::*;
    import fpba_scoreboard_pkg::*;

    // Codes the package leaves unnamed: both fall back to defined behaviour
    localparam logic [1:0] OP_UNKNOWN  = 2'd3;
    localparam logic [1:0] POL_UNKNOWN = 2'd3;

    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 11;
    localparam int ALLOC_LATENCY    = NUM_BLOCKS + 2;  // accept to next accept
    localparam int MAX_GAP          = 40;
    localparam int RANDOM_PER_PHASE = 86;
    // bound on the run, several times the length of the slowest run
    localparam int CYCLE_LIMIT      = 400000;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_item       i_item  = '0;
    logic        o_result_valid;
    t_result     o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    alloc_scoreboard sb;
    int unsigned     cycles = 0;

    fit_policy_block_allocator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: a hang anywhere ends the run as a failure
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Results last one cycle and cannot be held off, so take every strobe.
    // Values read here are the ones that stood before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_result(o_result);
    end

    // ------------------------------------------------------------------------
    // APB access: setup cycle, access cycle, then an idle cycle so that
    // back-to-back accesses never assign psel twice in one step.
    // ------------------------------------------------------------------------
    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic apb_read(logic [1:0] idx, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic verify_registers();
        logic [1:0]  regs [3];
        logic [31:0] d;
        regs = '{REG_FIT_POLICY, REG_FIXED_PART, REG_BLOCK_COUNT};
        foreach (regs[r]) begin
            apb_read(regs[r], d);
            sb.compare($sformatf("register %0d readback", regs[r]), sb.reg_value(regs[r]), d);
        end
    endtask

    // ------------------------------------------------------------------------
    // Command side. Called at a clock edge. start stays high between
    // back-to-back transactions; a nonzero gap first lowers it and waits it out.
    // After return the caller must either send again or settle straight
    // away, or the block would take the same transaction a second time.
    // ------------------------------------------------------------------------
    task automatic send_command(t_item it, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_command(it);
    endtask

    // Stop sending and wait until every outstanding result is in
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0 || busy);
        repeat (2) @(posedge i_clk);
    endtask

    function automatic int idle_gap(int pct);
        int g;
        g = 0;
        while (g < MAX_GAP && $urandom_range(99) < pct)
            g++;
        return g;
    endfunction

    function automatic t_item make_cmd(logic [1:0] op, logic [3:0] idx,
                                       logic [15:0] size, logic last);
        t_item it;
        it.op           = op;
        it.block_index  = idx;
        it.size         = size;
        it.last_request = last;
        return it;
    endfunction

    // Random transaction. Requests are mostly sized against what the blocks
    // actually hold so that grants, exact fits and near misses all turn up.
    function automatic t_item random_command();
        t_item it;
        int    k;
        int    blk;
        it.block_index  = 4'($urandom_range(NUM_BLOCKS - 1));
        it.last_request = ($urandom_range(7) == 0);
        it.size         = 16'($urandom);
        k   = $urandom_range(99);
        blk = $urandom_range(NUM_BLOCKS - 1);
        if (k < 62) begin
            it.op = OP_ALLOC;
            case ($urandom_range(9))
                0:       it.size = '0;
                1:       it.size = 16'hFFFF;
                2, 3, 4: it.size = 16'($urandom_range(1, 127));
                5, 6:    it.size = sb.remaining[blk];                 // exact fit
                7:       it.size = sb.remaining[blk] - 16'($urandom_range(3));
                8:       it.size = 16'($urandom);
                default: it.size = sb.remaining[blk] + 16'd1;         // just too big
            endcase
        end else if (k < 80) begin
            it.op = OP_LOAD;
            case ($urandom_range(9))
                0:       it.size = '0;
                1:       it.size = 16'hFFFF;
                2, 3, 4: it.size = 16'($urandom_range(1, 255));
                5, 6:    it.size = 16'd64 << $urandom_range(2);       // ties
                default: it.size = 16'($urandom);
            endcase
        end else if (k < 93) begin
            it.op = OP_RESTORE;
        end else begin
            it.op = OP_UNKNOWN;
        end
        return it;
    endfunction

    // One register setting, then a run of random transactions. Now and then
    // the sender holds off until the block has drained completely.
    task automatic run_phase(logic [1:0] policy, logic fixed, logic [4:0] count,
                             int idle_pct);
        apb_write(REG_FIT_POLICY,  32'(policy));
        apb_write(REG_FIXED_PART,  32'(fixed));
        apb_write(REG_BLOCK_COUNT, 32'(count));
        verify_registers();
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_command(random_command(), idle_gap(idle_pct));
            if ($urandom_range(49) == 0)
                settle();
        end
        settle();
    endtask

    initial begin
        logic [15:0] load_sizes [NUM_BLOCKS];
        sb = new();
        load_sizes = '{16'd0, 16'd100, 16'd300, 16'd100, 16'd50, 16'd1000, 16'd300,
                       16'd7, 16'd2048, 16'd100, 16'h8000, 16'd12, 16'd500, 16'd300,
                       16'd64, 16'hFFFF};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of the registers
        verify_registers();

        // Directed part at reset settings (first fit, dynamic, all blocks).
        // Every block gets a size before anything reads the table; the
        // last-request mark on a load must be ignored.
        for (int i = 0; i < NUM_BLOCKS; i++)
            send_command(make_cmd(OP_LOAD, 4'(i), load_sizes[i], i == 3), 0);
        send_command(make_cmd(OP_ALLOC, 4'd0, 16'd0, 1'b0), 0);      // zero size fits block 0
        send_command(make_cmd(OP_ALLOC, 4'd0, 16'hFFFF, 1'b0), 0);   // largest block, empties it
        send_command(make_cmd(OP_ALLOC, 4'd0, 16'hFFFF, 1'b0), 0);   // nothing fits
        send_command(make_cmd(OP_ALLOC, 4'd0, 16'h8001, 1'b1), 0);   // refused, closes batch
        send_command(make_cmd(OP_UNKNOWN, 4'hF, 16'hFFFF, 1'b1), 0); // no effect
        send_command(make_cmd(OP_RESTORE, 4'd0, 16'd0, 1'b0), 0);
        send_command(make_cmd(OP_ALLOC, 4'd0, 16'd301, 1'b0), 0);
        send_command(make_cmd(OP_ALLOC, 4'd0, 16'd300, 1'b0), 0);
        settle();

        // Settings sweep: every policy incl. the unused code, both partition
        // modes, block counts of zero, one, full and beyond the table.
        // Idle patterns: none, sender idle 79 in 100, sender idle 33 in 100.
        run_phase(POL_FIRST,   1'b0, 5'd16, 0);
        run_phase(POL_BEST,    1'b0, 5'd16, 79);
        run_phase(POL_WORST,   1'b0, 5'd16, 33);
        run_phase(POL_BEST,    1'b1, 5'd16, 0);
        run_phase(POL_WORST,   1'b1, 5'd16, 79);
        run_phase(POL_FIRST,   1'b1, 5'd16, 33);
        run_phase(POL_UNKNOWN, 1'b0, 5'd8,  0);
        run_phase(POL_BEST,    1'b0, 5'd31, 79);
        run_phase(POL_WORST,   1'b0, 5'd1,  33);
        run_phase(POL_FIRST,   1'b0, 5'd0,  0);
        run_phase(POL_UNKNOWN, 1'b1, 5'd17, 79);
        run_phase(POL_BEST,    1'b1, 5'($urandom_range(2, 15)), 33);
        run_phase(POL_WORST,   1'b0, 5'd16, 0);

        // nothing outstanding now; let the clock run on idle before the verdict
        repeat (2 * ALLOC_LATENCY) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/fpba_pkg.sv
hw/rtl/fpba_cell.sv
hw/rtl/fit_policy_block_allocator.sv
verif/fpba_scoreboard_pkg.sv
verif/fit_policy_block_allocator_tb.sv
